// File: rtl/assert_macros.svh
// assertion macros used by the projection module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lpcp_pkg.sv
// shared constants and types of the point projection pipeline
`timescale 1ns / 1ps

package lpcp_pkg;
    localparam int POINT_WIDTH     = 24;
    localparam int PIXEL_FRAC_BITS = 4;

    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 3;

    localparam int IN_TDATA_W  = ((3 * POINT_WIDTH + 7) / 8) * 8;
    localparam int NORM_W      = 20;
    localparam int DEPTH_W     = 23;
    localparam int OUT_TDATA_W = ((2 * NORM_W + DEPTH_W + 7) / 8) * 8;

    // camera coordinate and divider widths
    localparam int C_W        = POINT_WIDTH + 5;
    localparam int DEN_W      = C_W - 1;
    localparam int NUM_W      = C_W + 16;
    localparam int Q_W        = NORM_W + 1;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0,
        REG_ROW1,
        REG_ROW2,
        REG_FOCAL,
        REG_RADIAL,
        REG_TANGENT,
        REG_IMAGE
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_VISIBLE,
        ST_BEHIND,
        ST_OUTSIDE
    } t_status;
endpackage

// File: rtl/lpcp_div.sv
// pipelined restoring divider for the normalized image coordinate
`timescale 1ns / 1ps

module lpcp_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [lpcp_pkg::NUM_W-1:0]         i_num,
    input  logic [lpcp_pkg::DEN_W-1:0]         i_den,
    input  logic                               i_neg,
    output logic signed [lpcp_pkg::NORM_W-1:0] o_quot
);
    import lpcp_pkg::*;

    localparam int HEAD_W = NUM_W - Q_W;
    localparam logic [Q_W-1:0] Q_LIM = Q_W'(1) << (NORM_W - 1);

    logic [DEN_W-1:0] h_rem [DIV_STAGES+1];
    logic [Q_W-1:0]   h_low [DIV_STAGES+1];
    logic [Q_W-1:0]   h_q   [DIV_STAGES+1];
    logic [DEN_W-1:0] h_den [DIV_STAGES+1];
    logic             h_neg [DIV_STAGES+1];
    logic             h_ovf [DIV_STAGES+1];

    logic [DEN_W-1:0] n_rem [DIV_STAGES];
    logic [Q_W-1:0]   n_low [DIV_STAGES];
    logic [Q_W-1:0]   n_q   [DIV_STAGES];

    logic [DEN_W-1:0] r_rem [DIV_STAGES];
    logic [Q_W-1:0]   r_low [DIV_STAGES];
    logic [Q_W-1:0]   r_q   [DIV_STAGES];
    logic [DEN_W-1:0] r_den [DIV_STAGES];
    logic             r_neg [DIV_STAGES];
    logic             r_ovf [DIV_STAGES];

    logic [HEAD_W-1:0]  w_head;
    logic [Q_W-1:0]     w_mag;
    logic signed [Q_W:0] w_neg_val;

    // a quotient that needs more than Q_W bits is flagged up front and saturated
    assign w_head   = i_num[NUM_W-1:Q_W];
    assign h_rem[0] = DEN_W'(w_head);
    assign h_low[0] = i_num[Q_W-1:0];
    assign h_q[0]   = '0;
    assign h_den[0] = i_den;
    assign h_neg[0] = i_neg;
    assign h_ovf[0] = (DEN_W'(w_head) >= i_den);

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        always_comb begin
            logic [DEN_W:0]   t;
            logic [DEN_W-1:0] rem;
            logic [Q_W-1:0]   low;
            logic [Q_W-1:0]   q;
            rem = h_rem[s];
            low = h_low[s];
            q   = h_q[s];
            for (int k = 0; k < DIV_STEPS; k++) begin
                t   = {rem, low[Q_W-1]};
                low = {low[Q_W-2:0], 1'b0};
                if (t >= {1'b0, h_den[s]}) begin
                    t = t - {1'b0, h_den[s]};
                    q = {q[Q_W-2:0], 1'b1};
                end else begin
                    q = {q[Q_W-2:0], 1'b0};
                end
                rem = t[DEN_W-1:0];
            end
            n_rem[s] = rem;
            n_low[s] = low;
            n_q[s]   = q;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_q[s]   <= n_q[s];
                r_den[s] <= h_den[s];
                r_neg[s] <= h_neg[s];
                r_ovf[s] <= h_ovf[s];
            end
        end

        assign h_rem[s+1] = r_rem[s];
        assign h_low[s+1] = r_low[s];
        assign h_q[s+1]   = r_q[s];
        assign h_den[s+1] = r_den[s];
        assign h_neg[s+1] = r_neg[s];
        assign h_ovf[s+1] = r_ovf[s];
    end

    always_comb begin
        w_mag = (h_ovf[DIV_STAGES] || (h_q[DIV_STAGES] > Q_LIM)) ? Q_LIM : h_q[DIV_STAGES];
        w_neg_val = -$signed({1'b0, w_mag});
        if (h_neg[DIV_STAGES]) begin
            o_quot = w_neg_val[NORM_W-1:0];
        end else if (w_mag == Q_LIM) begin
            o_quot = {1'b0, {(NORM_W-1){1'b1}}};
        end else begin
            o_quot = w_mag[NORM_W-1:0];
        end
    end
endmodule

// File: rtl/lidar_point_camera_projection.sv
// lidar point to camera pixel projection with lens distortion, fully pipelined
//
//  channel  | direction | content
//  ---------+-----------+------------------------------------------------
//  s        | in        | tdata: point_x, point_y, point_z
//  m        | out       | tdata: pixel_u, pixel_v, depth; tuser: status
//  cfg      | in        | register index and value, write only
//
//  one point per cycle while the output is not stalled; the divider pipeline depth is
//  set by the 21-bit quotient of the two dividers at 3 bits per stage.
//  reset clears the valid bits and the configuration registers; results in flight are dropped.
//  a stall on the output freezes every stage, so nothing is lost or repeated.
`timescale 1ns / 1ps

module lidar_point_camera_projection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // point_x, point_y, point_z
    input  logic [lpcp_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // pixel_u, pixel_v, depth, zero fill
    output logic [lpcp_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // status
    output logic [1:0]                          o_m_tuser,
    input  logic                                i_cfg_we,
    input  logic [lpcp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lpcp_pkg::CFG_W-1:0]          i_cfg_data
);
    import lpcp_pkg::*;

`include "assert_macros.svh"

    localparam int PW         = POINT_WIDTH;
    localparam int PROD_W     = PW + 14;
    localparam int ACC_W      = PW + 16;
    localparam int SH         = 20 - PIXEL_FRAC_BITS;
    localparam int NUM_STAGES = 3 + DIV_STAGES + 13;
    localparam int SIDE_LEN   = DIV_STAGES + 12;
    localparam int SQ_W       = 2 * NORM_W;
    localparam int XX_W       = 23;
    localparam int R2_W       = 24;
    localparam int XY_W       = 24;
    localparam int R4F_W      = 2 * R2_W;
    localparam int K1R2_W     = 16 + R2_W + 1;
    localparam int SUM2_W     = R2_W + 1;
    localparam int T1_W       = 16 + XY_W;
    localparam int T2_W       = 16 + SUM2_W + 1;
    localparam int DS_W       = 44;
    localparam int R4_W       = 31;
    localparam int D_W        = 31;
    localparam int R6F_W      = R4_W + R2_W;
    localparam int K2R4_W     = 16 + R4_W + 1;
    localparam int R6_W       = 39;
    localparam int K3R6_W     = 16 + R6_W + 1;
    localparam int F_W        = 58;
    localparam int G_W        = 45;
    localparam int GLO_W      = 22;
    localparam int GHI_W      = G_W - GLO_W;
    localparam int PP_W       = NORM_W + GLO_W + 1;
    localparam int XG_W       = 66;
    localparam int XD_W       = 51;
    localparam int UF_W       = 68;
    localparam int UL_W       = UF_W - SH + 1;
    localparam int WS_W       = 16 + PIXEL_FRAC_BITS;

    // configuration
    logic [CFG_W-1:0] r_row [3];
    logic [CFG_W-1:0] r_focal;
    logic [47:0]      r_rad;
    logic [31:0]      r_tan;
    logic [31:0]      r_img;

    logic signed [13:0] w_m   [3][3];
    logic signed [17:0] w_off [3];
    logic signed [15:0] w_k1, w_k2, w_k3, w_p1, w_p2;
    logic [14:0]        w_fx, w_fy, w_cx, w_cy;
    logic [WS_W-1:0]    w_wsc, w_hsc;

    logic                  w_adv;
    logic [NUM_STAGES-1:0] r_vld;
    logic signed [PW-1:0]  w_p [3];

    // stage 1 to 3
    logic signed [PROD_W-1:0] r1_prod [3][3];
    logic signed [C_W-1:0]    w_c  [3];
    logic signed [C_W-1:0]    r2_c [3];
    logic                     w_behind;
    logic [DEPTH_W-1:0]       w_depth;
    logic [DEN_W-1:0]         w_den;
    logic [C_W-1:0]           w_abs_x, w_abs_y;
    logic [NUM_W-1:0]         r3_num_x, r3_num_y;
    logic [DEN_W-1:0]         r3_den;
    logic                     r3_neg_x, r3_neg_y, r3_behind;
    logic [DEPTH_W-1:0]       r3_depth;

    logic                     r_sd_behind [SIDE_LEN];
    logic [DEPTH_W-1:0]       r_sd_depth  [SIDE_LEN];

    logic signed [NORM_W-1:0] w_x, w_y;

    // distortion stages
    logic signed [NORM_W-1:0] r_a_x, r_a_y, r_b_x, r_b_y, r_c_x, r_c_y, r_d_x, r_d_y;
    logic signed [NORM_W-1:0] r_e_x, r_e_y, r_f_x, r_f_y, r_g_x, r_g_y, r_h_x, r_h_y;
    logic signed [SQ_W-1:0]   r_a_xx, r_a_yy, r_a_xy;
    logic [XX_W-1:0]          w_xx, w_yy, r_b_xx, r_b_yy;
    logic signed [XY_W-1:0]   w_xy, r_b_xy;
    logic [R2_W-1:0]          w_r2, r_b_r2, r_c_r2, r_d_r2;
    logic [SUM2_W-1:0]        w_sx, w_sy;
    logic [R4F_W-1:0]         r_c_r4f;
    logic signed [K1R2_W-1:0] r_c_k1r2, r_d_k1r2, r_e_k1r2, r_f_k1r2, r_g_k1r2;
    logic signed [T1_W-1:0]   r_c_t1, r_c_t4;
    logic signed [T2_W-1:0]   r_c_t2, r_c_t3;
    logic [R4_W-1:0]          w_r4, r_d_r4;
    logic signed [D_W-1:0]    w_dx, w_dy;
    logic signed [D_W-1:0]    r_d_dx, r_d_dy, r_e_dx, r_e_dy, r_f_dx, r_f_dy;
    logic signed [D_W-1:0]    r_g_dx, r_g_dy, r_h_dx, r_h_dy, r_i_dx, r_i_dy;
    logic [R6F_W-1:0]         r_e_r6f;
    logic signed [K2R4_W-1:0] r_e_k2r4, r_f_k2r4, r_g_k2r4;
    logic [R6_W-1:0]          w_r6, r_f_r6;
    logic signed [K3R6_W-1:0] r_g_k3r6;
    logic signed [G_W-1:0]    w_g, r_h_g;
    logic signed [PP_W-1:0]   r_i_plx, r_i_phx, r_i_ply, r_i_phy;
    logic signed [XD_W-1:0]   w_xd, w_yd, r_j_xd, r_j_yd;
    logic signed [UF_W-1:0]   r_k_u, r_k_v;
    logic signed [UL_W-1:0]   w_u, w_v, r_l_u, r_l_v;

    // output stage
    logic                     w_inside;
    logic [NORM_W-1:0]        w_ou, w_ov;
    logic [NORM_W-1:0]        r_o_u, r_o_v;
    logic [DEPTH_W-1:0]       r_o_depth;
    t_status                  r_o_status;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= '0;
            r_row[1] <= '0;
            r_row[2] <= '0;
            r_focal  <= '0;
            r_rad    <= '0;
            r_tan    <= '0;
            r_img    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ROW0:    r_row[0] <= i_cfg_data;
                REG_ROW1:    r_row[1] <= i_cfg_data;
                REG_ROW2:    r_row[2] <= i_cfg_data;
                REG_FOCAL:   r_focal  <= i_cfg_data;
                REG_RADIAL:  r_rad    <= i_cfg_data[47:0];
                REG_TANGENT: r_tan    <= i_cfg_data[31:0];
                REG_IMAGE:   r_img    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_m[r][c] = r_row[r][14*c +: 14];
            end
            w_off[r] = r_row[r][42 +: 18];
        end
    end

    assign w_k1  = r_rad[15:0];
    assign w_k2  = r_rad[31:16];
    assign w_k3  = r_rad[47:32];
    assign w_p1  = r_tan[15:0];
    assign w_p2  = r_tan[31:16];
    assign w_fx  = r_focal[14:0];
    assign w_fy  = r_focal[29:15];
    assign w_cx  = r_focal[44:30];
    assign w_cy  = r_focal[59:45];
    assign w_wsc = WS_W'(r_img[15:0]) << PIXEL_FRAC_BITS;
    assign w_hsc = WS_W'(r_img[31:16]) << PIXEL_FRAC_BITS;

    // ------------------------------------------------------------- handshake
    assign w_adv      = !r_vld[NUM_STAGES-1] || i_m_tready;
    assign o_s_tready = w_adv;
    assign o_m_tvalid = r_vld[NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_s_tvalid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_p[i] = i_s_tdata[PW*i +: PW];
        end
    end

    // ---------------------------------------------------- camera transform
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        for (int r = 0; r < 3; r++) begin
            acc = ACC_W'(r1_prod[r][0]) + ACC_W'(r1_prod[r][1]) + ACC_W'(r1_prod[r][2])
                + ACC_W'(2048);
            w_c[r] = C_W'(acc >>> 12) + C_W'(w_off[r]);
        end
    end

    always_comb begin
        w_behind = r2_c[2][C_W-1] || (r2_c[2] == '0);
        w_den    = r2_c[2][DEN_W-1:0];
        w_abs_x  = r2_c[0][C_W-1] ? C_W'(-r2_c[0]) : C_W'(r2_c[0]);
        w_abs_y  = r2_c[1][C_W-1] ? C_W'(-r2_c[1]) : C_W'(r2_c[1]);
        if (w_behind) begin
            w_depth = '0;
        end else if (64'(r2_c[2]) > 64'sd8388607) begin
            w_depth = {DEPTH_W{1'b1}};
        end else begin
            w_depth = DEPTH_W'(r2_c[2]);
        end
    end

    // ----------------------------------------------------------- dividers
    lpcp_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r3_num_x),
        .i_den  (r3_den),
        .i_neg  (r3_neg_x),
        .o_quot (w_x)
    );

    lpcp_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r3_num_y),
        .i_den  (r3_den),
        .i_neg  (r3_neg_y),
        .o_quot (w_y)
    );

    // --------------------------------------------------------- distortion
    always_comb begin
        logic signed [SQ_W:0]  s2;
        logic signed [SQ_W-1:0] sxx, syy, sxy;
        sxx  = (r_a_xx + SQ_W'(32768)) >>> 16;
        syy  = (r_a_yy + SQ_W'(32768)) >>> 16;
        sxy  = (r_a_xy + SQ_W'(32768)) >>> 16;
        s2   = ((SQ_W+1)'(r_a_xx) + (SQ_W+1)'(r_a_yy) + (SQ_W+1)'(32768)) >>> 16;
        w_xx = sxx[XX_W-1:0];
        w_yy = syy[XX_W-1:0];
        w_xy = sxy[XY_W-1:0];
        w_r2 = s2[R2_W-1:0];
    end

    assign w_sx = SUM2_W'(r_b_r2) + (SUM2_W'(r_b_xx) << 1);
    assign w_sy = SUM2_W'(r_b_r2) + (SUM2_W'(r_b_yy) << 1);

    always_comb begin
        logic [R4F_W:0]        s4;
        logic signed [DS_W-1:0] sdx, sdy;
        s4   = ((R4F_W+1)'(r_c_r4f) + (R4F_W+1)'(32768)) >> 16;
        w_r4 = s4[R4_W-1:0];
        sdx  = ((DS_W'(r_c_t1) <<< 1) + DS_W'(r_c_t2) + DS_W'(4096)) >>> 13;
        sdy  = (DS_W'(r_c_t3) + (DS_W'(r_c_t4) <<< 1) + DS_W'(4096)) >>> 13;
        w_dx = sdx[D_W-1:0];
        w_dy = sdy[D_W-1:0];
    end

    always_comb begin
        logic [R6F_W:0] s6;
        s6   = ((R6F_W+1)'(r_e_r6f) + (R6F_W+1)'(32768)) >> 16;
        w_r6 = s6[R6_W-1:0];
    end

    // radial factor in Q.29, rounded to Q.16
    always_comb begin
        logic signed [F_W-1:0] f;
        f   = F_W'(2**29) + F_W'(r_g_k1r2) + F_W'(r_g_k2r4) + F_W'(r_g_k3r6) + F_W'(4096);
        f   = f >>> 13;
        w_g = f[G_W-1:0];
    end

    // recombine the split x*g partial products
    always_comb begin
        logic signed [XG_W-1:0] xg, yg;
        xg   = (XG_W'(r_i_phx) <<< GLO_W) + XG_W'(r_i_plx) + XG_W'(32768);
        yg   = (XG_W'(r_i_phy) <<< GLO_W) + XG_W'(r_i_ply) + XG_W'(32768);
        xg   = xg >>> 16;
        yg   = yg >>> 16;
        w_xd = XD_W'(xg) + XD_W'(r_i_dx);
        w_yd = XD_W'(yg) + XD_W'(r_i_dy);
    end

    always_comb begin
        logic signed [UF_W-1:0] su, sv;
        su  = (r_k_u + UF_W'(2**(SH-1))) >>> SH;
        sv  = (r_k_v + UF_W'(2**(SH-1))) >>> SH;
        w_u = UL_W'(su);
        w_v = UL_W'(sv);
    end

    // bounds test on the unsaturated position
    always_comb begin
        w_inside = (r_l_u >= 0) && (r_l_u < UL_W'($signed({1'b0, w_wsc})))
                && (r_l_v >= 0) && (r_l_v < UL_W'($signed({1'b0, w_hsc})));
        if (r_l_u > UL_W'(2**(NORM_W-1) - 1)) begin
            w_ou = {1'b0, {(NORM_W-1){1'b1}}};
        end else if (r_l_u < -UL_W'(2**(NORM_W-1))) begin
            w_ou = {1'b1, {(NORM_W-1){1'b0}}};
        end else begin
            w_ou = r_l_u[NORM_W-1:0];
        end
        if (r_l_v > UL_W'(2**(NORM_W-1) - 1)) begin
            w_ov = {1'b0, {(NORM_W-1){1'b1}}};
        end else if (r_l_v < -UL_W'(2**(NORM_W-1))) begin
            w_ov = {1'b1, {(NORM_W-1){1'b0}}};
        end else begin
            w_ov = r_l_v[NORM_W-1:0];
        end
    end

    // ------------------------------------------------------ pipeline regs
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_prod[r][c] <= PROD_W'(w_m[r][c]) * PROD_W'(w_p[c]);
                end
                r2_c[r] <= w_c[r];
            end

            r3_num_x  <= {w_abs_x, 16'b0} + NUM_W'(w_den >> 1);
            r3_num_y  <= {w_abs_y, 16'b0} + NUM_W'(w_den >> 1);
            r3_den    <= w_den;
            r3_neg_x  <= r2_c[0][C_W-1];
            r3_neg_y  <= r2_c[1][C_W-1];
            r3_behind <= w_behind;
            r3_depth  <= w_depth;

            r_sd_behind[0] <= r3_behind;
            r_sd_depth[0]  <= r3_depth;
            for (int i = 1; i < SIDE_LEN; i++) begin
                r_sd_behind[i] <= r_sd_behind[i-1];
                r_sd_depth[i]  <= r_sd_depth[i-1];
            end

            r_a_x  <= w_x;
            r_a_y  <= w_y;
            r_a_xx <= SQ_W'(w_x) * SQ_W'(w_x);
            r_a_yy <= SQ_W'(w_y) * SQ_W'(w_y);
            r_a_xy <= SQ_W'(w_x) * SQ_W'(w_y);

            r_b_x  <= r_a_x;
            r_b_y  <= r_a_y;
            r_b_xx <= w_xx;
            r_b_yy <= w_yy;
            r_b_xy <= w_xy;
            r_b_r2 <= w_r2;

            r_c_x    <= r_b_x;
            r_c_y    <= r_b_y;
            r_c_r2   <= r_b_r2;
            r_c_r4f  <= R4F_W'(r_b_r2) * R4F_W'(r_b_r2);
            r_c_k1r2 <= K1R2_W'(w_k1) * K1R2_W'($signed({1'b0, r_b_r2}));
            r_c_t1   <= T1_W'(w_p1) * T1_W'(r_b_xy);
            r_c_t2   <= T2_W'(w_p2) * T2_W'($signed({1'b0, w_sx}));
            r_c_t3   <= T2_W'(w_p1) * T2_W'($signed({1'b0, w_sy}));
            r_c_t4   <= T1_W'(w_p2) * T1_W'(r_b_xy);

            r_d_x    <= r_c_x;
            r_d_y    <= r_c_y;
            r_d_r2   <= r_c_r2;
            r_d_r4   <= w_r4;
            r_d_k1r2 <= r_c_k1r2;
            r_d_dx   <= w_dx;
            r_d_dy   <= w_dy;

            r_e_x    <= r_d_x;
            r_e_y    <= r_d_y;
            r_e_r6f  <= R6F_W'(r_d_r4) * R6F_W'(r_d_r2);
            r_e_k1r2 <= r_d_k1r2;
            r_e_k2r4 <= K2R4_W'(w_k2) * K2R4_W'($signed({1'b0, r_d_r4}));
            r_e_dx   <= r_d_dx;
            r_e_dy   <= r_d_dy;

            r_f_x    <= r_e_x;
            r_f_y    <= r_e_y;
            r_f_r6   <= w_r6;
            r_f_k1r2 <= r_e_k1r2;
            r_f_k2r4 <= r_e_k2r4;
            r_f_dx   <= r_e_dx;
            r_f_dy   <= r_e_dy;

            r_g_x    <= r_f_x;
            r_g_y    <= r_f_y;
            r_g_k3r6 <= K3R6_W'(w_k3) * K3R6_W'($signed({1'b0, r_f_r6}));
            r_g_k1r2 <= r_f_k1r2;
            r_g_k2r4 <= r_f_k2r4;
            r_g_dx   <= r_f_dx;
            r_g_dy   <= r_f_dy;

            r_h_x  <= r_g_x;
            r_h_y  <= r_g_y;
            r_h_g  <= w_g;
            r_h_dx <= r_g_dx;
            r_h_dy <= r_g_dy;

            // g split into a low unsigned and a high signed part
            r_i_plx <= PP_W'(r_h_x) * PP_W'($signed({1'b0, r_h_g[GLO_W-1:0]}));
            r_i_phx <= PP_W'(r_h_x) * PP_W'($signed(r_h_g[G_W-1:GLO_W]));
            r_i_ply <= PP_W'(r_h_y) * PP_W'($signed({1'b0, r_h_g[GLO_W-1:0]}));
            r_i_phy <= PP_W'(r_h_y) * PP_W'($signed(r_h_g[G_W-1:GLO_W]));
            r_i_dx  <= r_h_dx;
            r_i_dy  <= r_h_dy;

            r_j_xd <= w_xd;
            r_j_yd <= w_yd;

            r_k_u <= UF_W'(r_j_xd) * UF_W'($signed({1'b0, w_fx}))
                   + UF_W'($signed({1'b0, w_cx, 16'b0}));
            r_k_v <= UF_W'(r_j_yd) * UF_W'($signed({1'b0, w_fy}))
                   + UF_W'($signed({1'b0, w_cy, 16'b0}));

            r_l_u <= w_u;
            r_l_v <= w_v;

            if (r_sd_behind[SIDE_LEN-1]) begin
                r_o_u      <= '0;
                r_o_v      <= '0;
                r_o_depth  <= '0;
                r_o_status <= ST_BEHIND;
            end else begin
                r_o_u      <= w_ou;
                r_o_v      <= w_ov;
                r_o_depth  <= r_sd_depth[SIDE_LEN-1];
                r_o_status <= w_inside ? ST_VISIBLE : ST_OUTSIDE;
            end
        end
    end

    assign o_m_tdata = OUT_TDATA_W'({r_o_depth, r_o_v, r_o_u});
    assign o_m_tuser = r_o_status;

    // ---------------------------------------------------------- assertions
    `ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, !o_m_tvalid, o_s_tready, "input blocked with output free")
    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_vld[0], "accepted point missing in stage one")
    `ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, r_vld == $past(r_vld), "pipeline moved during stall")
    `ASSERT_IMP(a_behind_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == ST_BEHIND), o_m_tdata == '0, "behind camera point with nonzero data")
endmodule
